[sv/kbt_pkg.sv]
// ----------------------------------------------------------------------------
// kbt_pkg: shared types and constants for the key backlight timeout core
// Event codes, beat payload structs, lamp levels and timing defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package kbt_pkg;

  // Timing defaults (ticks are 1/60 s)
  localparam int unsigned TicksPerSecondDef   = 60;
  localparam int unsigned PressHoldSecondsDef = 15;

  localparam int unsigned SettingW = 16;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned LevelW   = 8;

  localparam logic signed [SettingW-1:0] SettingReset     = 16'sd90;
  localparam logic signed [SettingW-1:0] SettingAlwaysOn  = -16'sd1;
  localparam logic signed [SettingW-1:0] SettingAlwaysOff = 16'sd0;

  localparam logic [LevelW-1:0] LevelOn  = 8'd255;
  localparam logic [LevelW-1:0] LevelOff = 8'd0;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_PRESS   = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_ENABLE  = 3'd3,
    ACT_DISABLE = 3'd4,
    ACT_APPLY   = 3'd5,
    ACT_DISPLAY = 3'd6
  } act_e;

  typedef struct packed {
    logic [2:0] action;
    logic       lock_idle;
    logic       display_normal;
  } kbt_in_t;

  typedef struct packed {
    logic              lamp_write;
    logic [LevelW-1:0] lamp_level;
    logic              timer_running;
  } kbt_out_t;

endpackage

`default_nettype wire

[sv/key_backlight_timeout_core.sv]
// ----------------------------------------------------------------------------
// key_backlight_timeout_core
// Touch-key backlight controller with a one-shot auto-off timer in ticks.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  in      | in  | in_valid_i/in_ready_o | kbt_in_t  (action, lock, disp)
//  out     | out | out_valid_o/out_ready_i | kbt_out_t (write, level, timer)
//  cfg     | in  | cfg_valid_i/cfg_ready_o | duration_setting, 16 bit signed
//
//  - Every accepted event beat yields one registered result beat.
//  - Sustained rate is one event per cycle while out_ready_i holds high; the
//    event decode and 16-bit decrement sit between state and result registers.
//  - A two-entry output (result register plus skid) keeps in_ready_o high
//    while one result waits; in_ready_o drops only when both are full.
//  - Reset: lamp off, timer disarmed, setting 90 ticks, output empty.
//  - cfg is always ready; a write takes effect for events accepted after it.
//
`default_nettype none

module key_backlight_timeout_core #(
  parameter int unsigned TICKS_PER_SECOND   = kbt_pkg::TicksPerSecondDef,
  parameter int unsigned PRESS_HOLD_SECONDS = kbt_pkg::PressHoldSecondsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire kbt_pkg::kbt_in_t                    in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output kbt_pkg::kbt_out_t                        out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic signed [kbt_pkg::SettingW-1:0] cfg_data_i
);

  // Press hold time in ticks, saturated to the counter width, at least one
  localparam longint unsigned HoldProd =
      longint'(PRESS_HOLD_SECONDS) * longint'(TICKS_PER_SECOND);
  localparam longint unsigned TicksMax = (64'd1 << kbt_pkg::TicksW) - 64'd1;
  localparam logic [kbt_pkg::TicksW-1:0] HoldTicks =
      (HoldProd > TicksMax) ? kbt_pkg::TicksW'(TicksMax) :
      (HoldProd == 0)       ? kbt_pkg::TicksW'(1) :
                              kbt_pkg::TicksW'(HoldProd);

  logic signed [kbt_pkg::SettingW-1:0] setting_q;
  logic                                lamp_q, lamp_d;
  logic                                armed_q, armed_d;
  logic [kbt_pkg::TicksW-1:0]          ticks_q, ticks_d;

  logic                                out_valid_q, skid_valid_q;
  kbt_pkg::kbt_out_t                   out_q, skid_q;

  logic                                in_acc, out_pop;
  logic                                wrote;
  logic                                set_on, set_off;
  logic [kbt_pkg::TicksW-1:0]          rel_ticks, tick_dec;
  kbt_pkg::kbt_out_t                   res;

  assign in_ready_o  = !skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_pop     = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign set_on    = (setting_q == kbt_pkg::SettingAlwaysOn);
  assign set_off   = (setting_q == kbt_pkg::SettingAlwaysOff);
  // Negative settings other than always-on behave as a one-tick timeout
  assign rel_ticks = (setting_q > 0) ? kbt_pkg::TicksW'(setting_q)
                                     : kbt_pkg::TicksW'(1);
  assign tick_dec  = (ticks_q != '0) ? ticks_q - kbt_pkg::TicksW'(1) : ticks_q;

  // Event decode: next lamp/timer state and the write flag
  always_comb begin
    lamp_d  = lamp_q;
    armed_d = armed_q;
    ticks_d = ticks_q;
    wrote   = 1'b0;
    unique case (kbt_pkg::act_e'(in_data_i.action))
      kbt_pkg::ACT_TICK: begin
        if (armed_q) begin
          ticks_d = tick_dec;
          if (tick_dec == '0) begin
            armed_d = 1'b0;
            lamp_d  = 1'b0;
            wrote   = 1'b1;
          end
        end
      end
      kbt_pkg::ACT_PRESS: begin
        armed_d = 1'b0;
        ticks_d = '0;
        if (!set_off) begin
          lamp_d  = 1'b1;
          wrote   = 1'b1;
          armed_d = 1'b1;
          ticks_d = HoldTicks;
        end
      end
      kbt_pkg::ACT_RELEASE: begin
        armed_d = 1'b0;
        ticks_d = '0;
        if (!set_on && !set_off) begin
          armed_d = 1'b1;
          ticks_d = rel_ticks;
        end
      end
      kbt_pkg::ACT_ENABLE: begin
        armed_d = 1'b0;
        ticks_d = '0;
        if (!set_off) begin
          lamp_d = 1'b1;
          wrote  = 1'b1;
          // idle lock: lamp on with no auto-off
          if (!in_data_i.lock_idle) begin
            armed_d = 1'b1;
            ticks_d = HoldTicks;
          end
        end
      end
      kbt_pkg::ACT_DISABLE: begin
        armed_d = 1'b0;
        ticks_d = '0;
        if (!set_on) begin
          lamp_d = 1'b0;
          wrote  = 1'b1;
        end
      end
      kbt_pkg::ACT_APPLY: begin
        armed_d = 1'b0;
        ticks_d = '0;
        wrote   = 1'b1;
        if (set_off) begin
          lamp_d = 1'b0;
        end else begin
          lamp_d = 1'b1;
          if (!set_on) begin
            armed_d = 1'b1;
            ticks_d = rel_ticks;
          end
        end
      end
      kbt_pkg::ACT_DISPLAY: begin
        if (in_data_i.display_normal && set_on) begin
          lamp_d = 1'b1;
          wrote  = 1'b1;
        end
      end
      default: begin
        // unused code: no write, state held
      end
    endcase
  end

  always_comb begin
    res.lamp_write    = wrote;
    res.lamp_level    = lamp_d ? kbt_pkg::LevelOn : kbt_pkg::LevelOff;
    res.timer_running = armed_d;
  end

  // Setting register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q <= kbt_pkg::SettingReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      setting_q <= cfg_data_i;
    end
  end

  // Lamp and timer state, updated on each accepted event beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q  <= 1'b0;
      armed_q <= 1'b0;
      ticks_q <= '0;
    end else if (in_acc) begin
      lamp_q  <= lamp_d;
      armed_q <= armed_d;
      ticks_q <= ticks_d;
    end
  end

  // Output register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  // Assertions
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (ticks_q != '0))
    else $error("timer armed with zero ticks left");

  a_disarmed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> (ticks_q == '0))
    else $error("ticks left while timer disarmed");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_valid_q) |=> out_valid_q)
    else $error("accepted beat did not reach the output register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && !skid_valid_q && in_acc) |=> !in_ready_o)
    else $error("ready stayed high with both output slots full");

endmodule

`default_nettype wire

[dv/key_backlight_timeout_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_backlight_timeout_core_test: self-checking bench for the backlight core
// Drives event beats through the valid/ready input channel and checks every
// result beat against a cycle-free model of the lamp and off timer. The
// duration setting is rewritten between phases while the core is drained.
// ----------------------------------------------------------------------------

module key_backlight_timeout_core_test;

  localparam int CycleLimit = 200000;

  // Press hold time in ticks, saturated to the timer width
  localparam int HoldProduct = kbt_pkg::PressHoldSecondsDef * kbt_pkg::TicksPerSecondDef;
  localparam logic [kbt_pkg::TicksW-1:0] HoldTicks =
      (HoldProduct > 65535) ? 16'hFFFF : (HoldProduct == 0) ? 16'd1 : 16'(HoldProduct);

  // --------------------------------------------------------------------------
  // Scoreboard: tracks lamp/timer state per accepted event beat and holds
  // the expected result beats in order.
  // --------------------------------------------------------------------------
  class lamp_scoreboard;
    kbt_pkg::kbt_out_t                    expected_q[$];
    logic signed [kbt_pkg::SettingW-1:0]  duration;
    logic                                 lamp_lit;
    logic                                 timer_armed;
    logic [kbt_pkg::TicksW-1:0]           ticks_left;
    int                                   errors;

    function new();
      duration    = kbt_pkg::SettingReset;
      lamp_lit    = 1'b0;
      timer_armed = 1'b0;
      ticks_left  = '0;
      errors      = 0;
    endfunction

    function void set_duration(logic signed [kbt_pkg::SettingW-1:0] v);
      duration = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void arm(logic [kbt_pkg::TicksW-1:0] t);
      timer_armed = 1'b1;
      ticks_left  = t;
    endfunction

    function void disarm();
      timer_armed = 1'b0;
      ticks_left  = '0;
    endfunction

    // Release timeout; any non-positive setting counts as one tick
    function logic [kbt_pkg::TicksW-1:0] release_ticks();
      return (duration > 16'sd0) ? kbt_pkg::TicksW'(duration) : 16'd1;
    endfunction

    function void log_event(kbt_pkg::kbt_in_t ev);
      kbt_pkg::kbt_out_t res;
      logic              wrote;
      wrote = 1'b0;
      case (ev.action)
        kbt_pkg::ACT_TICK: begin
          if (timer_armed) begin
            if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
              disarm();
              lamp_lit = 1'b0;
              wrote    = 1'b1;
            end
          end
        end
        kbt_pkg::ACT_PRESS: begin
          disarm();
          if (duration != kbt_pkg::SettingAlwaysOff) begin
            lamp_lit = 1'b1;
            wrote    = 1'b1;
            arm(HoldTicks);
          end
        end
        kbt_pkg::ACT_RELEASE: begin
          disarm();
          if (duration != kbt_pkg::SettingAlwaysOn && duration != kbt_pkg::SettingAlwaysOff)
            arm(release_ticks());
        end
        kbt_pkg::ACT_ENABLE: begin
          disarm();
          if (duration != kbt_pkg::SettingAlwaysOff) begin
            lamp_lit = 1'b1;
            wrote    = 1'b1;
            if (!ev.lock_idle) arm(HoldTicks);
          end
        end
        kbt_pkg::ACT_DISABLE: begin
          disarm();
          if (duration != kbt_pkg::SettingAlwaysOn) begin
            lamp_lit = 1'b0;
            wrote    = 1'b1;
          end
        end
        kbt_pkg::ACT_APPLY: begin
          disarm();
          wrote = 1'b1;
          if (duration == kbt_pkg::SettingAlwaysOff) begin
            lamp_lit = 1'b0;
          end else begin
            lamp_lit = 1'b1;
            if (duration != kbt_pkg::SettingAlwaysOn) arm(release_ticks());
          end
        end
        kbt_pkg::ACT_DISPLAY: begin
          if (ev.display_normal && duration == kbt_pkg::SettingAlwaysOn) begin
            lamp_lit = 1'b1;
            wrote    = 1'b1;
          end
        end
        default: ; // unused code: no write, state kept
      endcase
      res.lamp_write    = wrote;
      res.lamp_level    = lamp_lit ? kbt_pkg::LevelOn : kbt_pkg::LevelOff;
      res.timer_running = timer_armed;
      expected_q.push_back(res);
    endfunction

    function void check_result(kbt_pkg::kbt_out_t got);
      kbt_pkg::kbt_out_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.lamp_write !== exp.lamp_write) begin
        $display("%0t: lamp_write mismatch, expected %0d, actual %0d",
                 $time, exp.lamp_write, got.lamp_write);
        errors++;
      end
      if (got.lamp_level !== exp.lamp_level) begin
        $display("%0t: lamp_level mismatch, expected %0d, actual %0d",
                 $time, exp.lamp_level, got.lamp_level);
        errors++;
      end
      if (got.timer_running !== exp.timer_running) begin
        $display("%0t: timer_running mismatch, expected %0d, actual %0d",
                 $time, exp.timer_running, got.timer_running);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  kbt_pkg::kbt_in_t                     in_data_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  kbt_pkg::kbt_out_t                    out_data_o;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic signed [kbt_pkg::SettingW-1:0]  cfg_data_i;

  key_backlight_timeout_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  lamp_scoreboard                       sb;
  logic signed [kbt_pkg::SettingW-1:0]  duration_now;  // last setting written
  logic                                 quiet;         // 1: no idling on either side
  int                                   cycle_cnt;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sink side: drop ready about one cycle in ten unless in a quiet stretch.
  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 10);
  end

  // Monitor: all sampling happens at the rising edge, before the core's
  // registers update, so every handshake is seen with its pre-edge values.
  // An event taken at the same edge as a setting write still sees the old one.
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.log_event(in_data_i);
      if (cfg_valid_i && cfg_ready_o) sb.set_duration(cfg_data_i);
    end
  end

  // Watchdog on the cycle counter
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. All are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  function automatic kbt_pkg::kbt_in_t make_beat(kbt_pkg::act_e a, logic idle, logic normal);
    kbt_pkg::kbt_in_t ev;
    ev.action         = a;
    ev.lock_idle      = idle;
    ev.display_normal = normal;
    return ev;
  endfunction

  // Random action with random flags; includes the unused code 7
  function automatic kbt_pkg::kbt_in_t any_beat();
    kbt_pkg::kbt_in_t ev;
    ev.action         = 3'($urandom_range(0, 7));
    ev.lock_idle      = 1'($urandom);
    ev.display_normal = 1'($urandom);
    return ev;
  endfunction

  function automatic kbt_pkg::kbt_in_t flags_beat(kbt_pkg::act_e a);
    return make_beat(a, 1'($urandom), 1'($urandom));
  endfunction

  // One event beat. Valid is held from the last beat if no gap is taken,
  // so valid sees at most one update per time step.
  task automatic send_event(input kbt_pkg::kbt_in_t ev);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every result beat has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);  // margin after the last result beat is taken
  endtask

  task automatic write_duration(input logic signed [kbt_pkg::SettingW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b0;
    duration_now = v;
  endtask

  // Settings mix: the special values, both extremes, small negative values,
  // small and medium timeouts that expire often, and fully random words.
  function automatic logic signed [kbt_pkg::SettingW-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return kbt_pkg::SettingAlwaysOn;
      1:       return kbt_pkg::SettingAlwaysOff;
      2:       return 16'sh7FFF;
      3:       return 16'sh8000;
      4:       return -kbt_pkg::SettingW'($urandom_range(2, 20));
      8:       return kbt_pkg::SettingW'($urandom_range(13, 60));
      9:       return kbt_pkg::SettingW'($urandom);
      default: return kbt_pkg::SettingW'($urandom_range(1, 12));
    endcase
  endfunction

  // Mostly press / ticks / release / ticks runs, which is what gets the
  // release timer to expire; the rest is arbitrary events.
  task automatic key_burst(input int n_items);
    int sent;
    int rel;
    int n_hold;
    int n_wait;
    sent = 0;
    rel  = (duration_now > 16'sd0 && duration_now <= 16'sd60) ? int'(duration_now) : 4;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        n_hold = $urandom_range(0, 3);
        n_wait = $urandom_range(0, rel + 2);
        send_event(flags_beat(kbt_pkg::ACT_PRESS));
        repeat (n_hold) send_event(flags_beat(kbt_pkg::ACT_TICK));
        send_event(flags_beat(kbt_pkg::ACT_RELEASE));
        repeat (n_wait) send_event(flags_beat(kbt_pkg::ACT_TICK));
        sent += 2 + n_hold + n_wait;
      end else begin
        send_event(any_beat());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb           = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    cycle_cnt    = 0;
    duration_now = kbt_pkg::SettingReset;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset setting (90 ticks)
    send_event(make_beat(kbt_pkg::ACT_TICK, 1'b0, 1'b0));     // tick with timer idle
    send_event(make_beat(kbt_pkg::act_e'(3'd7), 1'b1, 1'b1)); // unused code is ignored
    send_event(make_beat(kbt_pkg::ACT_DISPLAY, 1'b0, 1'b1));  // no write unless always on
    send_event(make_beat(kbt_pkg::ACT_PRESS, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_ENABLE, 1'b1, 1'b0));   // idle lock: no timer
    send_event(make_beat(kbt_pkg::ACT_ENABLE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_DISABLE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_RELEASE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_APPLY, 1'b0, 1'b0));

    // Shortest timeout: expires on the first tick
    write_duration(16'sd1);
    send_event(make_beat(kbt_pkg::ACT_RELEASE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_TICK, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_APPLY, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_TICK, 1'b0, 1'b0));

    // Always on
    write_duration(kbt_pkg::SettingAlwaysOn);
    send_event(make_beat(kbt_pkg::ACT_RELEASE, 1'b0, 1'b0));  // no timer
    send_event(make_beat(kbt_pkg::ACT_DISABLE, 1'b0, 1'b0));  // no write
    send_event(make_beat(kbt_pkg::ACT_DISPLAY, 1'b0, 1'b1));  // relights
    send_event(make_beat(kbt_pkg::ACT_DISPLAY, 1'b1, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_APPLY, 1'b0, 1'b0));

    // Always off
    write_duration(kbt_pkg::SettingAlwaysOff);
    send_event(make_beat(kbt_pkg::ACT_PRESS, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_ENABLE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_APPLY, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_DISABLE, 1'b0, 1'b0));

    // Negative settings other than always on act as one tick
    write_duration(16'sh8000);
    send_event(make_beat(kbt_pkg::ACT_RELEASE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_TICK, 1'b0, 1'b0));

    // Largest timeout
    write_duration(16'sh7FFF);
    send_event(make_beat(kbt_pkg::ACT_RELEASE, 1'b0, 1'b0));
    send_event(make_beat(kbt_pkg::ACT_TICK, 1'b0, 1'b0));

    // Full press hold run: ticks until the hold timer expires, with a few
    // display changes (relight in always on, timer untouched) mixed in.
    write_duration(kbt_pkg::SettingAlwaysOn);
    send_event(make_beat(kbt_pkg::ACT_PRESS, 1'b0, 1'b0));
    repeat (int'(HoldTicks) + 20) begin
      if ($urandom_range(99) < 2) send_event(flags_beat(kbt_pkg::ACT_DISPLAY));
      else send_event(flags_beat(kbt_pkg::ACT_TICK));
    end

    // Random phases, a new setting each; phases 2..4 run with no idling.
    for (int ph = 0; ph < 12; ph++) begin
      write_duration(pick_duration());
      quiet = (ph >= 2 && ph <= 4);
      if (ph == 6) begin
        key_burst(40);
        drain();  // sender holds off until the core is empty
        key_burst(40);
      end else begin
        key_burst(80);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d result beats never arrived", $time, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
